FILE: hdl/brt_pkg.sv
// Shared types and constants for the bounded ranked table.
package brt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 64;
    localparam int MAX_RESULTS  = 64;
    localparam int RANK_W       = 7;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RANK  = 2'd1,
        CMD_RANGE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SHIFT,
        ST_QUERY,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_REMOVE,
        OP_INSERT,
        OP_READ
    } t_op;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        t_op         op;
        logic [63:0] key;
        logic [63:0] score;
        logic [63:0] stamp;
    } t_cell_ctl;

    // Address of the limit register.
    localparam logic [2:0] ADDR_MAX_ENTRIES = 3'd0;

endpackage

FILE: hdl/brt_if.sv
// Valid/ready channel interface used on both sides of the table.
interface brt_if #(
    parameter int PAYLOAD_W = 8
) ();
    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/brt_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
module brt_cell #(
    parameter int KEY_BITS = brt_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brt_pkg::t_cell_ctl   i_ctl,
    input  logic                 i_occ_prev,    // upstream cell occupied
    input  logic                 i_ahead_prev,  // upstream entry ranks ahead of new
    input  logic                 i_match_prev,  // key match at or above upstream
    input  logic [63:0]          i_prev_key,
    input  logic [63:0]          i_prev_score,
    input  logic [63:0]          i_prev_stamp,
    input  logic                 i_next_occ,
    input  logic [63:0]          i_next_key,
    input  logic [63:0]          i_next_score,
    input  logic [63:0]          i_next_stamp,
    input  logic                 i_first,
    input  logic                 i_allow_tail,  // this slot may take a new entry
    output logic                 o_occ,
    output logic                 o_ahead,
    output logic                 o_match_cum,
    output logic                 o_hit,
    output logic [63:0]          o_key,
    output logic [63:0]          o_score,
    output logic [63:0]          o_stamp
);
    logic              r_occ;
    logic [63:0]       r_key, r_score, r_stamp;
    logic              n_occ;
    logic [63:0]       n_key, n_score, n_stamp;
    logic              w_ahead, w_hit, w_match_cum, w_prev_ahead;
    logic [63:0]       xa, xb, ta, tb;

    always_comb begin
        xa = r_score ^ {1'b1, 63'd0};
        xb = i_ctl.score ^ {1'b1, 63'd0};
        ta = r_stamp ^ {1'b1, 63'd0};
        tb = i_ctl.stamp ^ {1'b1, 63'd0};
        if (xa != xb)      w_ahead = xa > xb;
        else if (ta != tb) w_ahead = ta < tb;
        else               w_ahead = r_key < i_ctl.key;
        w_ahead = w_ahead & r_occ;
        w_hit = r_occ && (r_key[KEY_BITS-1:0] == i_ctl.key[KEY_BITS-1:0]);
        w_match_cum = i_match_prev | w_hit;
        w_prev_ahead = i_first ? 1'b1 : i_ahead_prev;
    end

    always_comb begin
        n_occ = r_occ;
        n_key = r_key;
        n_score = r_score;
        n_stamp = r_stamp;
        unique case (i_ctl.op)
            brt_pkg::OP_REMOVE: begin
                if (w_match_cum) begin
                    n_occ = i_next_occ;
                    n_key = i_next_key;
                    n_score = i_next_score;
                    n_stamp = i_next_stamp;
                end
            end
            brt_pkg::OP_INSERT: begin
                if (w_prev_ahead && !w_ahead && i_allow_tail) begin
                    n_occ = 1'b1;
                    n_key = i_ctl.key;
                    n_score = i_ctl.score;
                    n_stamp = i_ctl.stamp;
                end else if (!w_prev_ahead && i_allow_tail) begin
                    n_occ = i_occ_prev;
                    n_key = i_prev_key;
                    n_score = i_prev_score;
                    n_stamp = i_prev_stamp;
                end
            end
            brt_pkg::OP_HOLD, brt_pkg::OP_READ: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_key <= n_key;
        r_score <= n_score;
        r_stamp <= n_stamp;
    end

    assign o_occ = r_occ;
    assign o_ahead = w_ahead;
    assign o_match_cum = w_match_cum;
    assign o_hit = w_hit;
    assign o_key = r_key;
    assign o_score = r_score;
    assign o_stamp = r_stamp;
endmodule

FILE: hdl/bounded_ranked_table_top.sv
// Top level of the bounded ranked table: control, APB limit register, cell row.
// Add: accept, then match/remove pass, then insert/shift pass; one item at a time.
// Rank query: result registered once the output is free; the next item is accepted back in idle.
// Range read: one entry per cycle while the output is not stalled; an empty range returns to idle with no output.
// Output is registered; a stalled output holds a query or read until its item is taken.
// Synchronous active-low reset empties the table and sets the limit to 64.
module bounded_ranked_table_top #(
    parameter int CAPACITY = brt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = brt_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brt_if.sink         i_in,
    brt_if.source       o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    brt_pkg::t_state    r_state, n_state;
    brt_pkg::t_cell_ctl w_ctl;
    logic [6:0]         r_max;
    logic [CW-1:0]      r_count, n_count;
    logic [63:0]        r_key, r_score, r_stamp;
    logic [CW-1:0]      r_idx, n_idx, r_end, n_end;
    logic [CW-1:0]      w_lim;
    logic               r_ovalid, n_ovalid;
    logic [201:0]       r_opay, n_opay;

    logic [CAPACITY-1:0] c_occ, c_ahead, c_mcum, c_hit;
    logic [63:0]         c_key   [CAPACITY];
    logic [63:0]         c_score [CAPACITY];
    logic [63:0]         c_stamp [CAPACITY];

    logic [CW-1:0]   w_hitpos;
    logic            w_hitany;

    assign pready = 1'b1;
    assign prdata = {25'd0, r_max};

    always_comb begin
        if (r_max == 7'd0)                              w_lim = CW'(1);
        else if ({{(32-7){1'b0}}, r_max} > 32'(CAPACITY)) w_lim = CW'(CAPACITY);
        else                                            w_lim = CW'(r_max);
    end

    always_comb begin
        w_hitpos = '0;
        w_hitany = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (c_hit[i]) begin
                w_hitpos = CW'(i + 1);
                w_hitany = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic allow;
            assign allow = (r_count < w_lim) ? (CW'(g) <= r_count)
                                             : (CW'(g) < r_count);
            brt_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_occ_prev   (g == 0 ? 1'b0 : c_occ[(g == 0) ? 0 : g-1]),
                .i_ahead_prev (g == 0 ? 1'b1 : c_ahead[(g == 0) ? 0 : g-1]),
                .i_match_prev (g == 0 ? 1'b0 : c_mcum[(g == 0) ? 0 : g-1]),
                .i_prev_key   (c_key[(g == 0) ? 0 : g-1]),
                .i_prev_score (c_score[(g == 0) ? 0 : g-1]),
                .i_prev_stamp (c_stamp[(g == 0) ? 0 : g-1]),
                .i_next_occ   (g == CAPACITY-1 ? 1'b0 : c_occ[(g == CAPACITY-1) ? g : g+1]),
                .i_next_key   (c_key[(g == CAPACITY-1) ? g : g+1]),
                .i_next_score (c_score[(g == CAPACITY-1) ? g : g+1]),
                .i_next_stamp (c_stamp[(g == CAPACITY-1) ? g : g+1]),
                .i_first      (g == 0),
                .i_allow_tail (allow),
                .o_occ        (c_occ[g]),
                .o_ahead      (c_ahead[g]),
                .o_match_cum  (c_mcum[g]),
                .o_hit        (c_hit[g]),
                .o_key        (c_key[g]),
                .o_score      (c_score[g]),
                .o_stamp      (c_stamp[g])
            );
        end
    endgenerate

    assign i_in.ready = (r_state == brt_pkg::ST_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.payload = r_opay;

    always_comb begin
        w_ctl.op = brt_pkg::OP_HOLD;
        w_ctl.key = r_key;
        w_ctl.score = r_score;
        w_ctl.stamp = r_stamp;
        n_state = r_state;
        n_count = r_count;
        n_idx = r_idx;
        n_end = r_end;
        n_ovalid = r_ovalid && !o_out.ready;
        n_opay = r_opay;
        unique case (r_state)
            brt_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_idx = CW'(i_in.payload[200:194]);
                    if ({{(32-7){1'b0}}, i_in.payload[207:201]} > 32'(r_count))
                        n_end = r_count;
                    else
                        n_end = CW'(i_in.payload[207:201]);
                    unique case (brt_pkg::t_cmd'(i_in.payload[1:0]))
                        brt_pkg::CMD_ADD:   n_state = brt_pkg::ST_MATCH;
                        brt_pkg::CMD_RANK:  n_state = brt_pkg::ST_QUERY;
                        brt_pkg::CMD_RANGE: n_state = brt_pkg::ST_READ;
                        brt_pkg::CMD_NONE:  n_state = brt_pkg::ST_IDLE;
                        default:            n_state = brt_pkg::ST_IDLE;
                    endcase
                end
            end
            brt_pkg::ST_MATCH: begin
                w_ctl.op = brt_pkg::OP_REMOVE;
                if (w_hitany) n_count = r_count - CW'(1);
                n_state = brt_pkg::ST_SHIFT;
            end
            brt_pkg::ST_SHIFT: begin
                w_ctl.op = brt_pkg::OP_INSERT;
                if (r_count < w_lim) n_count = r_count + CW'(1);
                n_state = brt_pkg::ST_IDLE;
            end
            brt_pkg::ST_QUERY: begin
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_opay = {1'b0, w_hitany, 7'(w_hitpos), 64'd0, 64'd0, 64'd0, 1'b1};
                    n_state = brt_pkg::ST_IDLE;
                end
            end
            brt_pkg::ST_READ: begin
                if (r_idx == '0 || r_idx > r_end) begin
                    n_state = brt_pkg::ST_IDLE;
                end else if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_opay = {1'b1, 1'b1, 7'(r_idx),
                              c_key[IW'(r_idx - CW'(1))],
                              c_score[IW'(r_idx - CW'(1))],
                              c_stamp[IW'(r_idx - CW'(1))],
                              (r_idx == r_end)};
                    n_idx = r_idx + CW'(1);
                    if (r_idx == r_end) n_state = brt_pkg::ST_IDLE;
                end
            end
            default: n_state = brt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brt_pkg::ST_IDLE;
            r_count <= '0;
            r_max <= 7'd64;
            r_ovalid <= 1'b0;
            r_idx <= '0;
            r_end <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
            r_idx <= n_idx;
            r_end <= n_end;
            if (psel && penable && pwrite && paddr == brt_pkg::ADDR_MAX_ENTRIES
                && r_count == '0)
                r_max <= pwdata[6:0];
        end
        r_opay <= n_opay;
        if (r_state == brt_pkg::ST_IDLE && i_in.valid) begin
            r_key <= i_in.payload[65:2] & ({64{1'b1}} >> (64 - KEY_BITS));
            r_score <= i_in.payload[129:66];
            r_stamp <= i_in.payload[193:130];
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == brt_pkg::ST_SHIFT |=> r_count <= w_lim)
        else $error("count above limit after add");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> $stable(r_opay))
        else $error("result changed while stalled");
endmodule
